>>> design/complex_arithmetic_unit_assert.svh
// ----------------------------------------------------------------------------
// complex arithmetic unit assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// consequent must hold in the same cycle
`define CAU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the next cycle
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// widths, codes, stage records and helpers of the complex arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

	localparam int W   = 32;            // word width
	localparam int F   = 16;            // fraction bits
	localparam int QB  = W + 1;         // quotient bits kept by the divider
	localparam int RW  = 2 * W + 1 + QB; // divider remainder width
	localparam int NST = QB + 5;        // pipeline stages

	localparam logic [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	typedef struct packed {
		cmd_t                cmd;
		logic signed [W-1:0] ar;
		logic signed [W-1:0] ai;
		logic signed [W-1:0] br;
		logic signed [W-1:0] bi;
	} in_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic signed [2*W-1:0] p_rr;
		logic signed [2*W-1:0] p_ii;
		logic signed [2*W-1:0] p_ir;
		logic signed [2*W-1:0] p_ri;
		logic signed [2*W-1:0] p_bbr;
		logic signed [2*W-1:0] p_bbi;
		logic signed [W:0]     as_re;
		logic signed [W:0]     as_im;
	} prod_t;

	typedef struct packed {
		cmd_t                cmd;
		logic signed [2*W:0] re;
		logic signed [2*W:0] im;
		logic [2*W:0]        den;
	} sum_t;

	typedef struct packed {
		logic          is_div;
		logic          div0;
		logic [W-1:0]  fin_re;
		logic [W-1:0]  fin_im;
		logic [1:0]    fin_st;
		logic          neg_re;
		logic          neg_im;
		logic          ovf_re;
		logic          ovf_im;
		logic [RW-1:0] rem_re;
		logic [RW-1:0] rem_im;
		logic [QB-1:0] q_re;
		logic [QB-1:0] q_im;
		logic [2*W:0]  den;
	} dv_t;

	typedef struct packed {
		logic [W-1:0] c_re;
		logic [W-1:0] c_im;
		logic [1:0]   st;
	} out_t;

	typedef struct packed {
		logic [W-1:0] val;
		logic         sat;
	} res_t;

	// clamp a sign and magnitude to the signed word range
	function automatic res_t sat_word(input logic neg, input logic [2*W:0] mag);
		res_t         r;
		logic [2*W:0] lim;
		lim = (2*W+1)'(1) << (W - 1);
		if (neg) begin
			if (mag > lim) begin
				r.val = W_MIN;
				r.sat = 1'b1;
			end else begin
				r.val = W'((~mag) + (2*W+1)'(1));
				r.sat = 1'b0;
			end
		end else begin
			if (mag > lim - (2*W+1)'(1)) begin
				r.val = W_MAX;
				r.sat = 1'b1;
			end else begin
				r.val = mag[W-1:0];
				r.sat = 1'b0;
			end
		end
		return r;
	endfunction

	// one restoring division step for both lanes, quotient bit bitp
	function automatic dv_t div_step(input dv_t x, input int unsigned bitp);
		logic [RW-1:0] dsh;
		dsh = RW'(x.den) << bitp;
		if (x.rem_re >= dsh) begin
			x.rem_re = x.rem_re - dsh;
			x.q_re   = x.q_re | (QB'(1) << bitp);
		end
		if (x.rem_im >= dsh) begin
			x.rem_im = x.rem_im - dsh;
			x.q_im   = x.q_im | (QB'(1) << bitp);
		end
		return x;
	endfunction

endpackage

`default_nettype wire

>>> design/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// pipelined complex add, subtract, multiply and divide on signed q16.16 words
// ----------------------------------------------------------------------------
// usage:
//   input channel s_*: s_tuser carries the command (add, sub, mul, div),
//   s_tdata carries operands a and b. a transaction completes when
//   s_tvalid and s_tready are both high at a rising clk edge.
//   output channel m_*: m_tdata carries the complex result, m_tuser the
//   status (ok, saturated, divide by zero), same handshake rule.
// path: input, multiply, sum and prep stages, 33 divider stages (one per
//   quotient bit) and the output stage, in that order;
//   every command takes the same path so results leave in order.
// throughput: one transaction per cycle while the output is not stalled, set by the fully pipelined
//   multipliers and the one-bit-per-stage restoring divider.
// stalls: each stage holds its item while the next one is full and stuck;
//   empty stages keep filling, so input is still taken while a result waits
//   until the whole pipeline is full.
// reset: arst_n clears all stage valid bits at once; no data is flushed
//   and the block is ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// a_real, a_imag, b_real, b_imag from bit 0 up
	input  logic [4*cau_pkg::W-1:0]   s_tdata,
	// command
	input  logic [1:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// c_real, c_imag from bit 0 up
	output logic [2*cau_pkg::W-1:0]   m_tdata,
	// status
	output logic [1:0]                m_tuser
);

	import cau_pkg::*;

	// stage valid bits and per-stage load enables
	logic [NST-1:0] vld_q;
	logic [NST:0]   ld;

	in_t   in_s1;
	prod_t prod_s2;
	sum_t  sum_s3;
	dv_t   prep_s4;
	dv_t   div_s5 [QB];   // divider stages, s5 onward
	dv_t   div_in [QB];
	dv_t   div_nx [QB];
	out_t  out_q;

	// a stage can load when it is empty or its item moves on
	always_comb begin
		ld[NST] = m_tready;
		for (int i = NST - 1; i >= 0; i--) begin
			ld[i] = !vld_q[i] || ld[i+1];
		end
	end

	assign s_tready = ld[0];
	assign m_tvalid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NST; i++) begin
				if (ld[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// s1: register the transaction
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			in_s1.cmd <= cmd_t'(s_tuser);
			in_s1.ar  <= s_tdata[W-1:0];
			in_s1.ai  <= s_tdata[2*W-1:W];
			in_s1.br  <= s_tdata[3*W-1:2*W];
			in_s1.bi  <= s_tdata[4*W-1:3*W];
		end
	end

	// s2: the six products, plus the add/sub result
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			prod_s2.cmd   <= in_s1.cmd;
			prod_s2.p_rr  <= in_s1.ar * in_s1.br;
			prod_s2.p_ii  <= in_s1.ai * in_s1.bi;
			prod_s2.p_ir  <= in_s1.ai * in_s1.br;
			prod_s2.p_ri  <= in_s1.ar * in_s1.bi;
			prod_s2.p_bbr <= in_s1.br * in_s1.br;
			prod_s2.p_bbi <= in_s1.bi * in_s1.bi;
			if (in_s1.cmd == CMD_SUB) begin
				prod_s2.as_re <= (W+1)'(in_s1.ar) - (W+1)'(in_s1.br);
				prod_s2.as_im <= (W+1)'(in_s1.ai) - (W+1)'(in_s1.bi);
			end else begin
				prod_s2.as_re <= (W+1)'(in_s1.ar) + (W+1)'(in_s1.br);
				prod_s2.as_im <= (W+1)'(in_s1.ai) + (W+1)'(in_s1.bi);
			end
		end
	end

	// s3: exact sums; for divide these are the numerators of a * conj(b)
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			sum_s3.cmd <= prod_s2.cmd;
			sum_s3.den <= {1'b0, prod_s2.p_bbr} + {1'b0, prod_s2.p_bbi};
			case (prod_s2.cmd)
				CMD_ADD, CMD_SUB: begin
					sum_s3.re <= (2*W+1)'(prod_s2.as_re);
					sum_s3.im <= (2*W+1)'(prod_s2.as_im);
				end
				CMD_MUL: begin
					sum_s3.re <= (2*W+1)'(prod_s2.p_rr) - (2*W+1)'(prod_s2.p_ii);
					sum_s3.im <= (2*W+1)'(prod_s2.p_ir) + (2*W+1)'(prod_s2.p_ri);
				end
				default: begin
					sum_s3.re <= (2*W+1)'(prod_s2.p_rr) + (2*W+1)'(prod_s2.p_ii);
					sum_s3.im <= (2*W+1)'(prod_s2.p_ir) - (2*W+1)'(prod_s2.p_ri);
				end
			endcase
		end
	end

	// s4: magnitudes; finish add/sub/mul, set up the divider
	logic [2*W:0] mag_re, mag_im, sh_re, sh_im;
	res_t         fr_re, fr_im;

	always_comb begin
		mag_re = sum_s3.re[2*W] ? ((~sum_s3.re) + (2*W+1)'(1)) : sum_s3.re;
		mag_im = sum_s3.im[2*W] ? ((~sum_s3.im) + (2*W+1)'(1)) : sum_s3.im;
		// truncation toward zero is a shift of the magnitude
		sh_re  = (sum_s3.cmd == CMD_MUL) ? (mag_re >> F) : mag_re;
		sh_im  = (sum_s3.cmd == CMD_MUL) ? (mag_im >> F) : mag_im;
		fr_re  = sat_word(sum_s3.re[2*W], sh_re);
		fr_im  = sat_word(sum_s3.im[2*W], sh_im);
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			prep_s4.is_div <= (sum_s3.cmd == CMD_DIV);
			prep_s4.div0   <= (sum_s3.den == '0);
			prep_s4.fin_re <= fr_re.val;
			prep_s4.fin_im <= fr_im.val;
			prep_s4.fin_st <= (fr_re.sat || fr_im.sat) ? ST_SAT : ST_OK;
			prep_s4.neg_re <= sum_s3.re[2*W];
			prep_s4.neg_im <= sum_s3.im[2*W];
			// quotient of 2^QB or more always saturates
			prep_s4.ovf_re <= ((RW'(mag_re) << F) >= (RW'(sum_s3.den) << QB));
			prep_s4.ovf_im <= ((RW'(mag_im) << F) >= (RW'(sum_s3.den) << QB));
			prep_s4.rem_re <= RW'(mag_re) << F;
			prep_s4.rem_im <= RW'(mag_im) << F;
			prep_s4.q_re   <= '0;
			prep_s4.q_im   <= '0;
			prep_s4.den    <= sum_s3.den;
		end
	end

	// s5 onward: one quotient bit per stage, msb first
	always_comb begin
		for (int j = 0; j < QB; j++) begin
			div_in[j] = (j == 0) ? prep_s4 : div_s5[(j == 0) ? 0 : j - 1];
			div_nx[j] = div_step(div_in[j], QB - 1 - j);
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < QB; j++) begin
			if (ld[4+j]) begin
				div_s5[j] <= div_nx[j];
			end
		end
	end

	// output stage: pick the result and saturate the quotient
	dv_t  dl;
	res_t qr_re, qr_im;
	out_t out_nx;

	always_comb begin
		dl    = div_s5[QB-1];
		qr_re = sat_word(dl.neg_re, (2*W+1)'(dl.q_re));
		qr_im = sat_word(dl.neg_im, (2*W+1)'(dl.q_im));
		if (dl.ovf_re) begin
			qr_re.val = dl.neg_re ? W_MIN : W_MAX;
			qr_re.sat = 1'b1;
		end
		if (dl.ovf_im) begin
			qr_im.val = dl.neg_im ? W_MIN : W_MAX;
			qr_im.sat = 1'b1;
		end
		if (!dl.is_div) begin
			out_nx.c_re = dl.fin_re;
			out_nx.c_im = dl.fin_im;
			out_nx.st   = dl.fin_st;
		end else if (dl.div0) begin
			out_nx.c_re = '0;
			out_nx.c_im = '0;
			out_nx.st   = ST_DIV0;
		end else begin
			out_nx.c_re = qr_re.val;
			out_nx.c_im = qr_im.val;
			out_nx.st   = (qr_re.sat || qr_im.sat) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[NST-1]) begin
			out_q <= out_nx;
		end
	end

	assign m_tdata = {out_q.c_im, out_q.c_re};
	assign m_tuser = out_q.st;

	// a refused input means the whole pipeline is full and the output stalled
	`CAU_ASSERT_NOW(a_full_stall, !s_tready, m_tvalid && !m_tready, "input refused without full stall")
	// an accepted transaction lands in the first stage
	`CAU_ASSERT_NEXT(a_take, s_tvalid && s_tready, vld_q[0], "accepted transaction lost at s1")
	// divide by zero gives a zero result
	`CAU_ASSERT_NOW(a_div0, m_tvalid && (m_tuser == ST_DIV0), m_tdata == '0, "div0 result not zero")
	// saturated status needs a clamped component
	`CAU_ASSERT_NOW(a_sat, m_tvalid && (m_tuser == ST_SAT), (out_q.c_re == W_MAX) || (out_q.c_re == W_MIN) || (out_q.c_im == W_MAX) || (out_q.c_im == W_MIN), "saturated status without clamp")

endmodule

`default_nettype wire
